// File: rtl/core/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

   // Field widths
   localparam int COEF_W    = 32;
   localparam int TOL_W     = 16;
   localparam int REQ_W     = 96;
   localparam int RSP_W     = 72;

   // Square root: 66-bit radicand, one result bit per stage
   localparam int SQ_STEPS  = 33;
   localparam int RAD_W     = 66;
   localparam int ROOT_W    = 33;
   localparam int REM_W     = 36;

   // Divider: 50-bit numerator magnitude, one quotient bit per stage
   localparam int DIV_STEPS = 50;
   localparam int NUM_W     = 50;

   // Register map (word address)
   localparam logic ADDR_TOL = 1'b0;

   // Root counts
   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;
   localparam logic [1:0] CNT_ALL  = 2'd3;

   // Discriminant limit past which the tolerance cannot matter
   localparam logic signed [63:0] Q_BIG = 64'sh0000_0100_0000_0000;

   localparam logic [NUM_W-1:0] SAT_POS = NUM_W'(64'h7FFF_FFFF);
   localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(64'h8000_0000);

   // What the back end does with a request
   typedef enum logic [3:0] {
      MODE_NONE = 4'b0001,
      MODE_LIN  = 4'b0010,
      MODE_DBL  = 4'b0100,
      MODE_TWO  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sq_lane_type;

   typedef struct packed {
      logic [COEF_W-1:0] rem;
      logic [NUM_W-1:0]  num;
   } div_lane_type;

   typedef struct packed {
      logic              ovf;
      logic [COEF_W-1:0] val;
   } sat_type;

   // Magnitude of a signed coefficient
   function automatic logic [COEF_W-1:0] abs32(input logic [COEF_W-1:0] v);
      return v[COEF_W-1] ? (COEF_W'(0) - v) : v;
   endfunction

   function automatic logic near_zero(input logic [COEF_W-1:0] v,
                                      input logic [TOL_W-1:0]  tol);
      return abs32(v) <= {{(COEF_W-TOL_W){1'b0}}, tol};
   endfunction

   // One restoring square root step, two radicand bits in
   function automatic sq_lane_type sqrt_step(input sq_lane_type x);
      logic [REM_W-1:0] rem_n;
      logic [REM_W-1:0] trial;
      sq_lane_type      y;
      rem_n  = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
      trial  = {1'b0, x.root, 2'b01};
      y.rad  = {x.rad[RAD_W-3:0], 2'b00};
      if (rem_n >= trial) begin
         y.rem  = rem_n - trial;
         y.root = {x.root[ROOT_W-2:0], 1'b1};
      end else begin
         y.rem  = rem_n;
         y.root = {x.root[ROOT_W-2:0], 1'b0};
      end
      return y;
   endfunction

   // One restoring division step, quotient bit shifts into num
   function automatic div_lane_type div_step(input div_lane_type x,
                                             input logic [COEF_W-1:0] d);
      logic [COEF_W:0] sh;
      div_lane_type    y;
      sh    = {x.rem, x.num[NUM_W-1]};
      y.num = {x.num[NUM_W-2:0], 1'b0};
      if (sh >= {1'b0, d}) begin
         sh       = sh - {1'b0, d};
         y.num[0] = 1'b1;
      end
      y.rem = sh[COEF_W-1:0];
      return y;
   endfunction

   // Signed magnitude to Q16.16 with saturation
   function automatic sat_type saturate(input logic neg, input logic [NUM_W-1:0] m);
      sat_type r;
      r.ovf = 1'b0;
      if (neg) begin
         if (m > SAT_NEG) begin
            r.ovf = 1'b1;
            r.val = 32'h8000_0000;
         end else begin
            r.val = COEF_W'(0) - m[COEF_W-1:0];
         end
      end else begin
         if (m > SAT_POS) begin
            r.ovf = 1'b1;
            r.val = 32'h7FFF_FFFF;
         end else begin
            r.val = m[COEF_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/quadratic_root_solver_unit.sv
`default_nettype none

// Real roots of a*x^2 + b*x + c = 0 for signed Q16.16 coefficients. The unit
// accepts one request per clock unless stalled and returns one response per
// request, in order, through the product, discriminant and classification
// registers, 33 square root stages (one root bit each), one numerator stage,
// 50 divider stages (one quotient bit each, two lanes side by side) and the
// saturating output register. Any stall on the response side freezes the whole
// pipe; req_tready follows rsp_tready whenever the output register holds data.
// zero_tolerance (byte address 0) is best written while no request is in flight.
module quadratic_root_solver_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [31:0] coef_a, [63:32] coef_b, [95:64] coef_c
   input  logic [qrs_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [1:0] root_count, [33:2] root_first, [65:34] root_second, [66] overflow
   output logic [qrs_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import qrs_pkg::*;

   typedef struct packed {
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] c;
      logic              nza;
      logic              nzb;
      logic              nzc;
      logic [63:0]       b2;
      logic [63:0]       ac;
   } s1_type;

   typedef struct packed {
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] c;
      logic              nza;
      logic              nzb;
      logic              nzc;
      logic [63:0]       q;
      logic [1:0]        odd;
   } s2_type;

   typedef struct packed {
      mode_type          mode;
      logic [1:0]        count;
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] c;
      sq_lane_type       lane;
   } sq_type;

   typedef struct packed {
      mode_type          mode;
      logic [1:0]        count;
      logic [COEF_W-1:0] dmag;
      logic              neg1;
      logic              neg2;
      div_lane_type      l1;
      div_lane_type      l2;
   } dv_type;

   typedef struct packed {
      logic              ovf;
      logic [COEF_W-1:0] r2;
      logic [COEF_W-1:0] r1;
      logic [1:0]        count;
   } out_type;

   logic              adv;
   logic [TOL_W-1:0]  tol_ff, tol_in;
   logic              s1v_ff, s2v_ff;
   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   logic              sqv_ff [0:SQ_STEPS];
   sq_type            sq_ff  [0:SQ_STEPS];
   sq_type            sq_in;
   logic              dvv_ff [0:DIV_STEPS];
   dv_type            dv_ff  [0:DIV_STEPS];
   dv_type            dv_in;
   logic              outv_ff;
   out_type           out_ff, out_in;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_TOL) ? {16'b0, tol_ff} : 32'b0;

   always_comb begin
      tol_in = tol_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == ADDR_TOL) begin
         tol_in = csr_pwdata[TOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
      end else begin
         tol_ff <= tol_in;
      end
   end

   // Whole pipe moves unless the output register is full and stalled
   assign adv        = !outv_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 1: near-zero tests and the two products
   always_comb begin
      s1_in.a   = req_tdata[31:0];
      s1_in.b   = req_tdata[63:32];
      s1_in.c   = req_tdata[95:64];
      s1_in.nza = near_zero(s1_in.a, tol_ff);
      s1_in.nzb = near_zero(s1_in.b, tol_ff);
      s1_in.nzc = near_zero(s1_in.c, tol_ff);
      s1_in.b2  = 64'($signed(s1_in.b) * $signed(s1_in.b));
      s1_in.ac  = 64'($signed(s1_in.a) * $signed(s1_in.c));
   end

   // Stage 2: q = floor(b^2/4) - a*c, delta = 4q + odd
   always_comb begin
      s2_in.a   = s1_ff.a;
      s2_in.b   = s1_ff.b;
      s2_in.c   = s1_ff.c;
      s2_in.nza = s1_ff.nza;
      s2_in.nzb = s1_ff.nzb;
      s2_in.nzc = s1_ff.nzc;
      s2_in.q   = {2'b00, s1_ff.b2[63:2]} - s1_ff.ac;
      s2_in.odd = s1_ff.b2[1:0];
   end

   // Stage 3: classify against the tolerance
   always_comb begin
      logic signed [63:0] q;
      logic signed [44:0] d;
      logic signed [44:0] tq;
      logic               two;
      logic               dbl;
      q  = $signed(s2_ff.q);
      d  = $signed({s2_ff.q[42:0], s2_ff.odd});
      tq = $signed({13'b0, tol_ff, 16'b0});
      if (q > Q_BIG) begin
         two = 1'b1;
         dbl = 1'b0;
      end else if (q < -Q_BIG) begin
         two = 1'b0;
         dbl = 1'b0;
      end else begin
         two = d > tq;
         dbl = !two && !(d < -tq);
      end
      sq_in.a         = s2_ff.a;
      sq_in.b         = s2_ff.b;
      sq_in.c         = s2_ff.c;
      sq_in.lane.rem  = '0;
      sq_in.lane.root = '0;
      sq_in.lane.rad  = {s2_ff.q, s2_ff.odd};
      if (s2_ff.nza) begin
         if (s2_ff.nzb) begin
            sq_in.mode  = MODE_NONE;
            sq_in.count = s2_ff.nzc ? CNT_ALL : CNT_NONE;
         end else begin
            sq_in.mode  = MODE_LIN;
            sq_in.count = CNT_ONE;
         end
      end else if (two) begin
         sq_in.mode  = MODE_TWO;
         sq_in.count = CNT_TWO;
      end else if (dbl) begin
         sq_in.mode  = MODE_DBL;
         sq_in.count = CNT_ONE;
      end else begin
         sq_in.mode  = MODE_NONE;
         sq_in.count = CNT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1v_ff    <= 1'b0;
         s2v_ff    <= 1'b0;
         sqv_ff[0] <= 1'b0;
      end else if (adv) begin
         s1v_ff    <= req_tvalid;
         s2v_ff    <= s1v_ff;
         sqv_ff[0] <= s2v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         sq_ff[0] <= sq_in;
      end
   end

   // Square root stages
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      sq_type nxt;
      always_comb begin
         nxt      = sq_ff[k];
         nxt.lane = sqrt_step(sq_ff[k].lane);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sqv_ff[k+1] <= sqv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k+1] <= nxt;
         end
      end
   end

   // Numerator stage: signs and magnitudes for both divider lanes
   always_comb begin
      logic signed [35:0] nb;
      logic signed [35:0] sx;
      logic signed [35:0] t1;
      logic signed [35:0] t2;
      logic [35:0]        m1;
      logic [35:0]        m2;
      sq_type             s;
      s  = sq_ff[SQ_STEPS];
      nb = -36'($signed(s.b));
      sx = $signed({3'b000, s.lane.root});
      t1 = nb + sx;
      t2 = nb - sx;
      m1 = t1[35] ? 36'(-t1) : t1;
      m2 = t2[35] ? 36'(-t2) : t2;
      dv_in.mode   = s.mode;
      dv_in.count  = s.count;
      dv_in.l1.rem = '0;
      dv_in.l2.rem = '0;
      dv_in.l2.num = '0;
      dv_in.neg2   = 1'b0;
      unique case (s.mode)
         MODE_LIN: begin
            dv_in.dmag   = abs32(s.b);
            dv_in.l1.num = {2'b00, abs32(s.c), 16'b0};
            dv_in.neg1   = !s.c[COEF_W-1] ^ s.b[COEF_W-1];
         end
         MODE_DBL: begin
            dv_in.dmag   = abs32(s.a);
            dv_in.l1.num = {3'b000, abs32(s.b), 15'b0};
            dv_in.neg1   = !s.b[COEF_W-1] ^ s.a[COEF_W-1];
         end
         MODE_TWO: begin
            dv_in.dmag   = abs32(s.a);
            dv_in.l1.num = {m1[34:0], 15'b0};
            dv_in.l2.num = {m2[34:0], 15'b0};
            dv_in.neg1   = t1[35] ^ s.a[COEF_W-1];
            dv_in.neg2   = t2[35] ^ s.a[COEF_W-1];
         end
         default: begin
            dv_in.dmag   = abs32(s.a);
            dv_in.l1.num = '0;
            dv_in.neg1   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvv_ff[0] <= 1'b0;
      end else if (adv) begin
         dvv_ff[0] <= sqv_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= dv_in;
      end
   end

   // Divider stages, two lanes sharing one divisor
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      dv_type nxt;
      always_comb begin
         nxt    = dv_ff[k];
         nxt.l1 = div_step(dv_ff[k].l1, dv_ff[k].dmag);
         nxt.l2 = div_step(dv_ff[k].l2, dv_ff[k].dmag);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dvv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dvv_ff[k+1] <= dvv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[k+1] <= nxt;
         end
      end
   end

   // Sign, saturation and output register
   always_comb begin
      sat_type z1;
      sat_type z2;
      dv_type  v;
      v            = dv_ff[DIV_STEPS];
      z1           = saturate(v.neg1, v.l1.num);
      z2           = saturate(v.neg2, v.l2.num);
      out_in.count = v.count;
      unique case (v.mode) inside
         MODE_LIN, MODE_DBL: begin
            out_in.r1  = z1.val;
            out_in.r2  = '0;
            out_in.ovf = z1.ovf;
         end
         MODE_TWO: begin
            out_in.r1  = z1.val;
            out_in.r2  = z2.val;
            out_in.ovf = z1.ovf | z2.ovf;
         end
         default: begin
            out_in.r1  = '0;
            out_in.r2  = '0;
            out_in.ovf = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outv_ff <= 1'b0;
      end else if (adv) begin
         outv_ff <= dvv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = outv_ff;
   assign rsp_tdata  = {5'b0, out_ff};

endmodule

`default_nettype wire

// File: rtl/core/qrs_checker.sv
`default_nettype none

module qrs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [qrs_pkg::RSP_W-1:0] rsp_tdata
);
   import qrs_pkg::*;

   logic [1:0]  cnt;
   logic [31:0] r1;
   logic [31:0] r2;
   logic        ovf;

   assign cnt = rsp_tdata[1:0];
   assign r1  = rsp_tdata[33:2];
   assign r2  = rsp_tdata[65:34];
   assign ovf = rsp_tdata[66];

   // A stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // An empty output stage never blocks requests
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   // No roots, or every x: both root fields zero, no overflow
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (cnt == CNT_NONE || cnt == CNT_ALL) |-> r1 == '0 && r2 == '0 && !ovf)
      else $error("root fields set without roots");

   // Single root leaves the second field clear
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cnt == CNT_ONE |-> r2 == '0)
      else $error("second root set for a single root");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (.*);

`default_nettype wire
